>>> sv/ggnh_pkg.sv
// Package for the geographic next-hop engine: codes, reset values, shared types.
// No dependencies.
`default_nettype none
package ggnh_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_WIDTH_DEF    = 16;
    localparam logic [7:0]  RESET_MAX_HOPS = 8'd32;
    localparam logic [63:0] RESET_EXPIRY   = 64'd2500000000;

    localparam logic [1:0] KIND_HELLO = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_ORIG  = 2'd2;
    localparam logic [1:0] KIND_TICK  = 2'd3;

    localparam logic [2:0] ACT_CONSUMED = 3'd0;
    localparam logic [2:0] ACT_TX       = 3'd1;
    localparam logic [2:0] ACT_DELIVER  = 3'd2;
    localparam logic [2:0] ACT_NO_ROUTE = 3'd3;
    localparam logic [2:0] ACT_HOP_LIM  = 3'd4;
    localparam logic [2:0] ACT_HELLO    = 3'd5;

    localparam logic [2:0] REG_SELF_ID = 3'd0;
    localparam logic [2:0] REG_SELF_X  = 3'd1;
    localparam logic [2:0] REG_SELF_Y  = 3'd2;
    localparam logic [2:0] REG_SELF_Z  = 3'd3;
    localparam logic [2:0] REG_MAX_HOP = 3'd4;
    localparam logic [2:0] REG_EXPIRY  = 3'd5;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] next_hop_id;
        logic [7:0]  hop_out;
        logic [8:0]  hops_taken;
    } result_t;
endpackage
`default_nettype wire

>>> sv/greedy_geo_next_hop_engine_top.sv
// Top level of the greedy geographic next-hop engine.
// Depends on ggnh_pkg, ggnh_front, ggnh_back, ggnh_out_q.
`default_nettype none
// Queue-style block: push/full in, empty/pop out, one result per transaction.
// Deliveries and broadcast originations are answered in the front end: the
// result is offered to the output queue straight from the front's slot.
// Hello and tick walk the neighbor table one entry per cycle, then offer
// their result to the output queue.
// Routed data and originations first take this node's own distance and,
// after the scan, drain the three-stage squared-distance pipeline. The
// front holds one transaction, so the next one is accepted at the edge where
// the current result enters the two-entry output queue; a full output queue
// stalls the input.
// Table valid bits clear at reset; no clearing pass. Config writes (index
// 0..5) must happen while idle.
module greedy_geo_next_hop_engine_top #(
    parameter int TABLE_DEPTH = ggnh_pkg::TABLE_DEPTH_DEF,
    parameter int ID_WIDTH    = ggnh_pkg::ID_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [63:0]         cfg_data,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          kind,
    input  wire logic [63:0]         now,
    input  wire logic [ID_WIDTH-1:0] peer_id,
    input  wire logic [ID_WIDTH-1:0] dst_id,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  pos_z,
    input  wire logic [7:0]          hop_count,
    output logic                     empty,
    input  wire logic                pop,
    output logic [2:0]               action,
    output logic [15:0]              next_hop_id,
    output logic [7:0]               hop_out,
    output logic [8:0]               hops_taken
);
    import ggnh_pkg::*;

    logic [ID_WIDTH-1:0] self_id_reg;
    logic signed [31:0]  self_x_reg, self_y_reg, self_z_reg;
    logic [7:0]          max_hops_reg;
    logic [63:0]         expiry_reg;

    // configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg <= '0; self_x_reg <= '0; self_y_reg <= '0; self_z_reg <= '0;
            max_hops_reg <= RESET_MAX_HOPS; expiry_reg <= RESET_EXPIRY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SELF_ID: self_id_reg  <= ID_WIDTH'(cfg_data[15:0]);
                REG_SELF_X:  self_x_reg   <= cfg_data[31:0];
                REG_SELF_Y:  self_y_reg   <= cfg_data[31:0];
                REG_SELF_Z:  self_z_reg   <= cfg_data[31:0];
                REG_MAX_HOP: max_hops_reg <= cfg_data[7:0];
                REG_EXPIRY:  expiry_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    logic dr_valid, dr_ready, tw_valid, tw_ready, br_valid, br_ready;
    result_t dr_res, br_res, q_res, out_res;
    logic [1:0] tw_kind;
    logic [63:0] tw_now;
    logic [ID_WIDTH-1:0] tw_id;
    logic signed [31:0] tw_x, tw_y, tw_z;
    logic [7:0] tw_hops;
    logic q_ready;

    ggnh_front #(.ID_WIDTH(ID_WIDTH)) u_front (
        .clk, .rst_n, .push, .full, .kind, .now, .peer_id, .dst_id,
        .pos_x, .pos_y, .pos_z, .hop_count,
        .self_id(self_id_reg), .max_hops(max_hops_reg),
        .dr_valid, .dr_res, .dr_ready,
        .tw_valid, .tw_kind, .tw_now, .tw_id, .tw_x, .tw_y, .tw_z, .tw_hops, .tw_ready
    );

    ggnh_back #(.TABLE_DEPTH(TABLE_DEPTH), .ID_WIDTH(ID_WIDTH)) u_back (
        .clk, .rst_n, .tw_valid, .tw_ready, .tw_kind, .tw_now, .tw_id,
        .tw_x, .tw_y, .tw_z, .tw_hops,
        .self_x(self_x_reg), .self_y(self_y_reg), .self_z(self_z_reg),
        .max_hops(max_hops_reg), .expiry_time(expiry_reg),
        .br_valid, .br_res, .br_ready
    );

    // only one path is active at a time: the front holds one item
    assign dr_ready = q_ready;
    assign br_ready = q_ready;
    assign q_res = br_valid ? br_res : dr_res;

    ggnh_out_q u_q (
        .clk, .rst_n, .in_valid(dr_valid || br_valid), .in_res(q_res),
        .in_ready(q_ready), .empty, .out_res, .pop
    );

    assign action      = out_res.action;
    assign next_hop_id = out_res.next_hop_id;
    assign hop_out     = out_res.hop_out;
    assign hops_taken  = out_res.hops_taken;
endmodule
`default_nettype wire

>>> sv/ggnh_front.sv
// Front end: input queue slot, classifies items into delivery, broadcast
// origination, or table work. Depends on ggnh_pkg.
`default_nettype none
module ggnh_front #(
    parameter int ID_WIDTH = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    output logic                     full,
    input  wire logic [1:0]          kind,
    input  wire logic [63:0]         now,
    input  wire logic [ID_WIDTH-1:0] peer_id,
    input  wire logic [ID_WIDTH-1:0] dst_id,
    input  wire logic signed [31:0]  pos_x,
    input  wire logic signed [31:0]  pos_y,
    input  wire logic signed [31:0]  pos_z,
    input  wire logic [7:0]          hop_count,
    input  wire logic [ID_WIDTH-1:0] self_id,
    input  wire logic [7:0]          max_hops,
    // direct result path
    output logic                     dr_valid,
    output ggnh_pkg::result_t        dr_res,
    input  wire logic                dr_ready,
    // table-work path
    output logic                     tw_valid,
    output logic [1:0]               tw_kind,
    output logic [63:0]              tw_now,
    output logic [ID_WIDTH-1:0]      tw_id,
    output logic signed [31:0]       tw_x,
    output logic signed [31:0]       tw_y,
    output logic signed [31:0]       tw_z,
    output logic [7:0]               tw_hops,
    input  wire logic                tw_ready
);
    import ggnh_pkg::*;
    localparam logic [ID_WIDTH-1:0] BCAST = {ID_WIDTH{1'b1}};

    logic        v_reg;
    logic [1:0]  k_reg;
    logic [63:0] n_reg;
    logic [ID_WIDTH-1:0] p_reg, d_reg;
    logic signed [31:0] x_reg, y_reg, z_reg;
    logic [7:0]  h_reg;
    logic        direct;
    logic [9:0]  taken;

    always_comb
    begin
        direct = ((k_reg == KIND_DATA) && (d_reg == BCAST || d_reg == self_id))
              || ((k_reg == KIND_ORIG) && (d_reg == BCAST));
        taken  = {2'b0, max_hops} - {2'b0, h_reg} + 10'd1;
        dr_res = '0;
        if (k_reg == KIND_DATA)
        begin
            dr_res.action     = ACT_DELIVER;
            dr_res.hops_taken = taken[9] ? 9'd0 : taken[8:0];
        end
        else
        begin
            dr_res.action      = ACT_TX;
            dr_res.next_hop_id = 16'(BCAST);
            dr_res.hop_out     = max_hops;
        end
    end

    assign dr_valid = v_reg && direct;
    assign tw_valid = v_reg && !direct;
    assign tw_kind  = k_reg;
    assign tw_now   = n_reg;
    assign tw_id    = (k_reg == KIND_HELLO) ? p_reg : d_reg;
    assign tw_x = x_reg;
    assign tw_y = y_reg;
    assign tw_z = z_reg;
    assign tw_hops = h_reg;
    assign full = v_reg && !(direct ? dr_ready : tw_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (!full)
            v_reg <= push;
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            k_reg <= kind; n_reg <= now; p_reg <= peer_id; d_reg <= dst_id;
            x_reg <= pos_x; y_reg <= pos_y; z_reg <= pos_z; h_reg <= hop_count;
        end
    end
endmodule
`default_nettype wire

>>> sv/ggnh_back.sv
// Back end: neighbor table and sequential scan for hello, tick and next-hop
// search. One entry per cycle; squared distance via a 3-stage datapath.
// Depends on ggnh_pkg.
`default_nettype none
module ggnh_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int ID_WIDTH    = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                tw_valid,
    output logic                     tw_ready,
    input  wire logic [1:0]          tw_kind,
    input  wire logic [63:0]         tw_now,
    input  wire logic [ID_WIDTH-1:0] tw_id,
    input  wire logic signed [31:0]  tw_x,
    input  wire logic signed [31:0]  tw_y,
    input  wire logic signed [31:0]  tw_z,
    input  wire logic [7:0]          tw_hops,
    input  wire logic signed [31:0]  self_x,
    input  wire logic signed [31:0]  self_y,
    input  wire logic signed [31:0]  self_z,
    input  wire logic [7:0]          max_hops,
    input  wire logic [63:0]         expiry_time,
    output logic                     br_valid,
    output ggnh_pkg::result_t        br_res,
    input  wire logic                br_ready
);
    import ggnh_pkg::*;
    localparam int IW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [ID_WIDTH-1:0] BCAST = {ID_WIDTH{1'b1}};

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SELF = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [ID_WIDTH-1:0]    nid_reg [TABLE_DEPTH];
    logic signed [31:0]     nx_reg [TABLE_DEPTH];
    logic signed [31:0]     ny_reg [TABLE_DEPTH];
    logic signed [31:0]     nz_reg [TABLE_DEPTH];
    logic [63:0]            lh_reg [TABLE_DEPTH];

    logic [2:0]  state_reg;
    logic [CW-1:0] cnt_reg;
    logic        found_reg, hit_reg, done_reg, stop_reg;
    logic [IW-1:0] slot_reg, free_reg;
    logic        have_free_reg;
    logic [65:0] best_reg;

    // distance pipeline: s1 diffs, s2 squares, s3 sum
    logic        s1_v, s2_v, s3_v, s1_self, s2_self, s3_self;
    logic [IW-1:0] s1_i, s2_i, s3_i;
    logic [32:0] s1_dx, s1_dy, s1_dz;
    logic [63:0] s2_qx, s2_qy, s2_qz;
    logic [65:0] s3_d;
    logic        s1_m, s2_m, s3_m;

    logic [IW-1:0] ci;
    logic          c_live, c_use;
    logic signed [32:0] ax, ay, az;
    logic [63:0]   age;

    function automatic logic [32:0] absd(input logic signed [32:0] d);
        absd = d[32] ? -d : d;
    endfunction

    assign ci  = cnt_reg[IW-1:0];
    assign age = tw_now - lh_reg[ci];
    assign c_live = valid_reg[ci] && (expiry_time == 64'd0 || age < expiry_time);
    assign c_use  = (state_reg == ST_SCAN) && tw_kind != KIND_HELLO
                 && tw_kind != KIND_TICK && c_live && !stop_reg;
    always_comb
    begin
        if (state_reg == ST_SELF)
        begin
            ax = {self_x[31], self_x}; ay = {self_y[31], self_y};
            az = {self_z[31], self_z};
        end
        else
        begin
            ax = {nx_reg[ci][31], nx_reg[ci]}; ay = {ny_reg[ci][31], ny_reg[ci]};
            az = {nz_reg[ci][31], nz_reg[ci]};
        end
    end

    assign tw_ready = (state_reg == ST_DONE) && br_ready;
    assign br_valid = (state_reg == ST_DONE);
    always_comb
    begin
        br_res = '0;
        case (tw_kind)
            KIND_HELLO: br_res.action = ACT_CONSUMED;
            KIND_TICK:
            begin
                br_res.action = ACT_HELLO;
                br_res.next_hop_id = 16'(BCAST);
                br_res.hop_out = 8'd1;
            end
            default:
            begin
                if (!found_reg)
                    br_res.action = ACT_NO_ROUTE;
                else if (tw_kind == KIND_DATA && tw_hops <= 8'd1)
                    br_res.action = ACT_HOP_LIM;
                else
                begin
                    br_res.action = ACT_TX;
                    br_res.next_hop_id = 16'(nid_reg[slot_reg]);
                    br_res.hop_out = (tw_kind == KIND_DATA) ? tw_hops - 8'd1 : max_hops;
                end
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        s1_v <= (state_reg == ST_SELF) || c_use;
        s1_self <= (state_reg == ST_SELF);
        s1_i <= ci;
        s1_m <= (state_reg == ST_SCAN) && nid_reg[ci] == tw_id;
        s1_dx <= absd(ax - {tw_x[31], tw_x});
        s1_dy <= absd(ay - {tw_y[31], tw_y});
        s1_dz <= absd(az - {tw_z[31], tw_z});
        s2_v <= s1_v; s2_self <= s1_self; s2_i <= s1_i; s2_m <= s1_m;
        s2_qx <= s1_dx[31:0] * s1_dx[31:0] + (s1_dx[32] ? 64'h8000_0000_0000_0000 : 64'd0);
        s2_qy <= s1_dy[31:0] * s1_dy[31:0] + (s1_dy[32] ? 64'h8000_0000_0000_0000 : 64'd0);
        s2_qz <= s1_dz[31:0] * s1_dz[31:0] + (s1_dz[32] ? 64'h8000_0000_0000_0000 : 64'd0);
        s3_v <= s2_v; s3_self <= s2_self; s3_i <= s2_i; s3_m <= s2_m;
        s3_d <= {2'b0, s2_qx} + {2'b0, s2_qy} + {2'b0, s2_qz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            cnt_reg <= '0;
            found_reg <= 1'b0; hit_reg <= 1'b0; stop_reg <= 1'b0; done_reg <= 1'b0;
            slot_reg <= '0; free_reg <= '0; have_free_reg <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                    if (tw_valid)
                    begin
                        cnt_reg <= '0; found_reg <= 1'b0; hit_reg <= 1'b0;
                        stop_reg <= 1'b0; have_free_reg <= 1'b0;
                        state_reg <= (tw_kind == KIND_HELLO || tw_kind == KIND_TICK)
                                   ? ST_SCAN : ST_SELF;
                    end
                ST_SELF: state_reg <= ST_SCAN;
                ST_SCAN:
                begin
                    if (tw_kind == KIND_HELLO)
                    begin
                        if (valid_reg[ci] && nid_reg[ci] == tw_id && !hit_reg)
                        begin
                            hit_reg <= 1'b1; slot_reg <= ci;
                        end
                        if (!valid_reg[ci] && !have_free_reg)
                        begin
                            have_free_reg <= 1'b1; free_reg <= ci;
                        end
                    end
                    else if (tw_kind == KIND_TICK)
                    begin
                        if (valid_reg[ci] && age >= expiry_time)
                            valid_reg[ci] <= 1'b0;
                    end
                    if (cnt_reg == CW'(TABLE_DEPTH - 1))
                        state_reg <= (tw_kind == KIND_HELLO) ? ST_DONE
                                   : (tw_kind == KIND_TICK) ? ST_DONE : ST_DRAIN;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (c_use && nid_reg[ci] == tw_id)
                        stop_reg <= 1'b1;
                end
                ST_DRAIN:
                    if (!s1_v && !s2_v && !s3_v)
                        state_reg <= ST_DONE;
                ST_DONE:
                    if (br_ready)
                        state_reg <= ST_IDLE;
                default: state_reg <= ST_IDLE;
            endcase

            if (state_reg == ST_SCAN && tw_kind == KIND_HELLO
                && cnt_reg == CW'(TABLE_DEPTH - 1))
            begin
                if (!hit_reg && !(valid_reg[ci] && nid_reg[ci] == tw_id)
                    && (have_free_reg || !valid_reg[ci]))
                    valid_reg[have_free_reg ? free_reg : ci] <= 1'b1;
            end

            // result of distance pipeline, in slot order; an id match ends the search
            if (s3_v && !done_reg)
            begin
                if (s3_self)
                    best_reg <= s3_d;
                else if (s3_m)
                begin
                    found_reg <= 1'b1; slot_reg <= s3_i; done_reg <= 1'b1;
                end
                else if (s3_d < best_reg)
                begin
                    best_reg <= s3_d; found_reg <= 1'b1; slot_reg <= s3_i;
                end
            end
            if (state_reg == ST_IDLE)
                done_reg <= 1'b0;
        end
    end

    // table writes for hello
    logic        wr_en;
    logic [IW-1:0] wr_i;
    always_comb
    begin
        wr_en = 1'b0; wr_i = ci;
        if (state_reg == ST_SCAN && tw_kind == KIND_HELLO && cnt_reg == CW'(TABLE_DEPTH - 1))
        begin
            if (hit_reg)
            begin
                wr_en = 1'b1; wr_i = slot_reg;
            end
            else if (valid_reg[ci] && nid_reg[ci] == tw_id)
            begin
                wr_en = 1'b1; wr_i = ci;
            end
            else if (have_free_reg)
            begin
                wr_en = 1'b1; wr_i = free_reg;
            end
            else if (!valid_reg[ci])
            begin
                wr_en = 1'b1; wr_i = ci;
            end
        end
    end
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            nid_reg[wr_i] <= tw_id; nx_reg[wr_i] <= tw_x; ny_reg[wr_i] <= tw_y;
            nz_reg[wr_i] <= tw_z; lh_reg[wr_i] <= tw_now;
        end
    end
endmodule
`default_nettype wire

>>> sv/ggnh_out_q.sv
// Result queue: small FIFO that merges the front and back result paths.
// Depends on ggnh_pkg.
`default_nettype none
module ggnh_out_q (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire ggnh_pkg::result_t in_res,
    output logic                   in_ready,
    output logic                   empty,
    output ggnh_pkg::result_t      out_res,
    input  wire logic              pop
);
    import ggnh_pkg::*;
    result_t mem_reg [FIFO_DEPTH];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic do_w, do_r;
    assign in_ready = cnt_reg != 2'(FIFO_DEPTH);
    assign empty = cnt_reg == 2'd0;
    assign out_res = mem_reg[rd_reg];
    assign do_w = in_valid && in_ready;
    assign do_r = pop && !empty;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= 1'b0; wr_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            if (do_w) wr_reg <= ~wr_reg;
            if (do_r) rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(do_w) - 2'(do_r);
        end
    end
    always_ff @(posedge clk)
    begin
        if (do_w) mem_reg[wr_reg] <= in_res;
    end
endmodule
`default_nettype wire

>>> dv/ggnh_checker.sv
// Checker for the geographic next-hop engine: keeps its own neighbor table,
// predicts one result per accepted transaction and compares. Depends on ggnh_pkg.
`timescale 1ns / 1ps
module ggnh_checker
    import ggnh_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        push,
    input  wire logic        full,
    input  wire logic [1:0]  kind,
    input  wire logic [63:0] now,
    input  wire logic [15:0] peer_id,
    input  wire logic [15:0] dst_id,
    input  wire logic [31:0] pos_x,
    input  wire logic [31:0] pos_y,
    input  wire logic [31:0] pos_z,
    input  wire logic [7:0]  hop_count,
    input  wire logic        empty,
    input  wire logic        pop,
    input  wire logic [2:0]  action,
    input  wire logic [15:0] next_hop_id,
    input  wire logic [7:0]  hop_out,
    input  wire logic [8:0]  hops_taken,
    output int               errors,
    output int               pending
);
    localparam int DEPTH = 16;
    localparam logic [15:0] BCAST = 16'hFFFF;

    logic [15:0] my_id;
    logic signed [31:0] my_x, my_y, my_z;
    logic [7:0]  hop_budget;
    logic [63:0] lifetime;

    logic               nb_valid [DEPTH];
    logic [15:0]        nb_id    [DEPTH];
    logic signed [31:0] nb_x     [DEPTH];
    logic signed [31:0] nb_y     [DEPTH];
    logic signed [31:0] nb_z     [DEPTH];
    logic [63:0]        nb_heard [DEPTH];

    result_t route_q[$];

    assign pending = route_q.size();

    function automatic logic [65:0] dist2(logic signed [31:0] ax, logic signed [31:0] ay,
                                          logic signed [31:0] az, logic signed [31:0] bx,
                                          logic signed [31:0] by, logic signed [31:0] bz);
        logic signed [32:0] dx, dy, dz;
        dx = ax - bx;
        dy = ay - by;
        dz = az - bz;
        return 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
    endfunction

    // greedy search: -1 when no live neighbor beats our own distance or matches dst
    function automatic int pick_next_hop(logic [63:0] t, logic [15:0] dst,
                                         logic signed [31:0] x, logic signed [31:0] y,
                                         logic signed [31:0] z);
        logic [65:0] best, d;
        int found;
        best  = dist2(my_x, my_y, my_z, x, y, z);
        found = -1;
        for (int i = 0; i < DEPTH; i++) begin
            if (!nb_valid[i]) continue;
            if (lifetime != 0 && (t - nb_heard[i]) >= lifetime) continue;
            d = dist2(nb_x[i], nb_y[i], nb_z[i], x, y, z);
            if (d < best)
            begin
                best  = d;
                found = i;
            end
            if (nb_id[i] == dst)
            begin
                found = i;
                break;
            end
        end
        return found;
    endfunction

    function automatic result_t route_item(logic [1:0] k, logic [63:0] t, logic [15:0] peer,
                                           logic [15:0] dst, logic signed [31:0] x,
                                           logic signed [31:0] y, logic signed [31:0] z,
                                           logic [7:0] hops);
        result_t r;
        int slot, free_slot, taken;
        r = '0;
        case (k)
            KIND_HELLO:
            begin
                r.action  = ACT_CONSUMED;
                free_slot = -1;
                for (int i = 0; i < DEPTH; i++) begin
                    if (nb_valid[i] && nb_id[i] == peer)
                    begin
                        nb_x[i] = x; nb_y[i] = y; nb_z[i] = z; nb_heard[i] = t;
                        return r;
                    end
                    if (!nb_valid[i] && free_slot < 0) free_slot = i;
                end
                if (free_slot >= 0)
                begin
                    nb_valid[free_slot] = 1'b1;
                    nb_id[free_slot]    = peer;
                    nb_x[free_slot] = x; nb_y[free_slot] = y; nb_z[free_slot] = z;
                    nb_heard[free_slot] = t;
                end
            end
            KIND_TICK:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (nb_valid[i] && (t - nb_heard[i]) >= lifetime) nb_valid[i] = 1'b0;
                r.action = ACT_HELLO; r.next_hop_id = BCAST; r.hop_out = 8'd1;
            end
            KIND_DATA:
            begin
                if (dst == BCAST || dst == my_id)
                begin
                    taken = int'(hop_budget) - int'(hops) + 1;
                    if (taken < 0) taken = 0;
                    r.action = ACT_DELIVER; r.hops_taken = 9'(taken);
                end
                else
                begin
                    slot = pick_next_hop(t, dst, x, y, z);
                    if (slot < 0) r.action = ACT_NO_ROUTE;
                    else if (hops <= 8'd1) r.action = ACT_HOP_LIM;
                    else
                    begin
                        r.action = ACT_TX; r.next_hop_id = nb_id[slot]; r.hop_out = hops - 8'd1;
                    end
                end
            end
            default:
            begin
                if (dst == BCAST)
                begin
                    r.action = ACT_TX; r.next_hop_id = BCAST; r.hop_out = hop_budget;
                end
                else
                begin
                    slot = pick_next_hop(t, dst, x, y, z);
                    if (slot < 0) r.action = ACT_NO_ROUTE;
                    else
                    begin
                        r.action = ACT_TX; r.next_hop_id = nb_id[slot]; r.hop_out = hop_budget;
                    end
                end
            end
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        result_t got, want;
        if (!rst_n)
        begin
            my_id = '0; my_x = '0; my_y = '0; my_z = '0;
            hop_budget = RESET_MAX_HOPS;
            lifetime   = RESET_EXPIRY;
            for (int i = 0; i < DEPTH; i++) nb_valid[i] = 1'b0;
            route_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SELF_ID: my_id = cfg_data[15:0];
                    REG_SELF_X:  my_x  = cfg_data[31:0];
                    REG_SELF_Y:  my_y  = cfg_data[31:0];
                    REG_SELF_Z:  my_z  = cfg_data[31:0];
                    REG_MAX_HOP: hop_budget = cfg_data[7:0];
                    REG_EXPIRY:  lifetime   = cfg_data;
                    default: ;
                endcase
            end
            // check the pop first so a same-edge push never counts as waiting
            if (pop && !empty)
            begin
                got = '{action, next_hop_id, hop_out, hops_taken};
                if (route_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10) $display("unexpected result %p", got);
                end
                else
                begin
                    want = route_q.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10) $display("mismatch: expected %p, actual %p", want, got);
                    end
                end
            end
            if (push && !full)
                route_q.push_back(route_item(kind, now, peer_id, dst_id, pos_x, pos_y, pos_z,
                                             hop_count));
        end
    end
endmodule

>>> dv/tb.sv
// Testbench top for the greedy geographic next-hop engine: clock, reset,
// configuration phases, directed and random stimulus, verdict.
// Depends on ggnh_pkg, greedy_geo_next_hop_engine_top, ggnh_checker.
`timescale 1ns / 1ps
module tb;
    import ggnh_pkg::*;

    logic        clk, rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        push, full, empty, pop;
    logic [1:0]  kind;
    logic [63:0] now;
    logic [15:0] peer_id, dst_id;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic [7:0]  hop_count;
    logic [2:0]  action;
    logic [15:0] next_hop_id;
    logic [7:0]  hop_out;
    logic [8:0]  hops_taken;
    int          errors, pending;

    // running clock of the simulated network; random items advance it
    logic [63:0] net_time;
    // stall bursts go away near the end of the run
    bit          calm;
    // small pools of ids and positions so hellos, lookups and hits overlap
    logic [15:0] id_pool[8];

    greedy_geo_next_hop_engine_top dut (.*);

    ggnh_checker chk (.*);

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #20000000;
        $display("FAILURE");
        $finish;
    end

    // result side: pop stays high except in random stall bursts
    initial begin
        int gap;
        pop = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 9) == 0)
            begin
                pop = 1'b0;
                gap = $urandom_range(1, 14);
                repeat (gap) @(negedge clk);
            end
            pop = 1'b1;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // wait for the engine to drain: every predicted result has been popped
    task automatic drain();
        while (pending != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // send one transaction; hold push until accepted at a rising edge
    task automatic send(logic [1:0] k, logic [63:0] t, logic [15:0] peer, logic [15:0] dst,
                        logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [7:0] hops);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        push = 1'b1; kind = k; now = t; peer_id = peer; dst_id = dst;
        pos_x = x; pos_y = y; pos_z = z; hop_count = hops;
        @(posedge clk);
        while (full) @(posedge clk);
        @(negedge clk);
        push = 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 4000)) - 2000);
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'($signed($urandom_range(0, 40)) - 20) << 8;
        endcase
    endfunction

    task automatic random_item();
        logic [1:0]  k;
        logic [15:0] peer, dst;
        logic [7:0]  hops;
        int          sel;
        sel = $urandom_range(0, 99);
        // time mostly creeps forward, sometimes leaps past the lifetime or wraps
        net_time += ($urandom_range(0, 19) == 0) ? {$urandom(), $urandom()}
                                                 : 64'($urandom_range(0, 400_000_000));
        peer = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65534))
                                           : id_pool[$urandom_range(0, 7)];
        dst  = id_pool[$urandom_range(0, 7)];
        case ($urandom_range(0, 9))
            0: dst = 16'hFFFF;
            1: dst = 16'($urandom());
            default: ;
        endcase
        hops = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2)) : 8'($urandom());
        if (sel < 35) k = KIND_HELLO;
        else if (sel < 75) k = KIND_DATA;
        else if (sel < 93) k = KIND_ORIG;
        else k = KIND_TICK;
        send(k, net_time, peer, dst, rand_coord(), rand_coord(), rand_coord(), hops);
    endtask

    initial begin
        rst_n = 1'b0; calm = 1'b0;
        cfg_we = 1'b0; cfg_index = REG_SELF_ID; cfg_data = '0;
        push = 1'b0; kind = KIND_HELLO; now = '0; peer_id = '0; dst_id = '0;
        pos_x = '0; pos_y = '0; pos_z = '0; hop_count = '0;
        net_time = 64'd1000;
        for (int i = 0; i < 8; i++) id_pool[i] = 16'(100 + i);
        id_pool[7] = 16'hFFFE;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: reset config first, then edge cases
        send(KIND_ORIG, 0, 0, 16'd5, 0, 0, 0, 0);                 // empty table: no route
        send(KIND_DATA, 0, 0, 16'hFFFF, 0, 0, 0, 8'd0);           // broadcast delivery
        send(KIND_DATA, 0, 0, 16'd0, 0, 0, 0, 8'd255);            // for self, floored
        send(KIND_HELLO, 10, 16'd7, 0, 32'h100, 0, 0, 0);
        send(KIND_HELLO, 20, 16'hFFFE, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send(KIND_DATA, 30, 0, 16'd9, 32'h1000, 0, 0, 8'd5);      // greedy forward
        send(KIND_DATA, 30, 0, 16'd9, 32'h1000, 0, 0, 8'd1);      // hop limit
        send(KIND_DATA, 30, 0, 16'd9, 32'h1000, 0, 0, 8'd0);
        send(KIND_DATA, 30, 0, 16'hFFFE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 8'd255);
        send(KIND_ORIG, 40, 0, 16'hFFFF, 0, 0, 0, 0);
        send(KIND_ORIG, 40, 0, 16'd7, 32'h8000_0000, 0, 0, 0);     // exact id match
        send(KIND_HELLO, 50, 16'd7, 0, 32'hFFFF_FF00, 0, 0, 0);   // refresh
        send(KIND_TICK, 64'd2_500_000_020, 0, 0, 0, 0, 0, 0);     // purges hello at 20
        send(KIND_DATA, 64'd2_500_000_030, 0, 16'hFFFE, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 8'd9);                                // stale entry skipped
        for (int i = 0; i < 17; i++)                              // overfill the table
            send(KIND_HELLO, 64'd2_500_000_100, 16'(200 + i), 0, 32'(i << 8), 0, 0, 0);
        send(KIND_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0, 0);

        // the sender holds off until the engine has drained
        drain();
        write_reg(REG_SELF_ID, 64'd65534);
        write_reg(REG_SELF_X, 64'hFFFF_FFFF_8000_0000);
        write_reg(REG_SELF_Y, 64'h7FFF_FFFF);
        write_reg(REG_SELF_Z, 64'd0);
        write_reg(REG_MAX_HOP, 64'd255);
        write_reg(REG_EXPIRY, 64'd0);
        write_reg(3'd7, 64'hDEAD);                                // unused index
        send(KIND_DATA, 5, 0, 16'd65534, 0, 0, 0, 8'd0);          // 256 hops taken
        send(KIND_TICK, 5, 0, 0, 0, 0, 0, 0);                     // zero lifetime purges all

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < 375; n++) begin
                if (phase == 3 && n == 250) calm = 1'b1;
                random_item();
            end
            drain();
            write_reg(REG_SELF_ID, (phase == 0) ? 64'd0 : 64'(id_pool[phase]));
            write_reg(REG_SELF_X, {32'h0, rand_coord()});
            write_reg(REG_SELF_Y, {32'h0, rand_coord()});
            write_reg(REG_SELF_Z, {32'h0, rand_coord()});
            write_reg(REG_MAX_HOP, (phase == 1) ? 64'd1 : 64'($urandom_range(1, 255)));
            write_reg(REG_EXPIRY, (phase == 0) ? 64'hFFFF_FFFF_FFFF_FFFF :
                                  (phase == 1) ? 64'd0 : 64'd900_000_000);
        end

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
